// ===== rtl/core/mtsp_pkg.sv =====
package mtsp_pkg;

  localparam int GS_N = 8;
  localparam int IP_N = 8;
  localparam int PWS_N = 32;
  localparam int AW = 32;
  localparam int PCW = 32;
  localparam int WW = 5;
  localparam int AGEW = 16;
  localparam int THRW = 6;

  localparam int GS_IW = (GS_N > 1) ? $clog2(GS_N) : 1;
  localparam int IP_IW = (IP_N > 1) ? $clog2(IP_N) : 1;
  localparam int PWS_IW = (PWS_N > 1) ? $clog2(PWS_N) : 1;
  localparam int SCAN_IW = (PWS_IW > GS_IW) ? ((PWS_IW > IP_IW) ? PWS_IW : IP_IW)
                                            : ((GS_IW > IP_IW) ? GS_IW : IP_IW);
  localparam int PCNT_W = $clog2(PWS_N + 1);

  localparam logic [AGEW-1:0] AGE_MAX = {AGEW{1'b1}};
  localparam logic [THRW-1:0] THR_RESET = THRW'(2);
  localparam logic [1:0] OBS_SLOTS = 2'd2;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_GS = 2'd1;
  localparam logic [1:0] SRC_IP = 2'd2;
  localparam logic [1:0] SRC_PWS = 2'd3;

  typedef enum logic [1:0] {TBL_GS, TBL_IP, TBL_PWS} tbl_t;

  typedef struct packed {
    logic latch;
    logic res_gs;
    logic res_ip;
    logic gs_touch;
    logic ip_touch;
    logic ip_obs;
    logic ip_alloc;
    logic pws_update;
    logic pws_alloc;
    logic cnt_capture;
    logic gs_promo;
    logic scan_start;
    tbl_t scan_tbl;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic gs_hit;
    logic ip_match;
    logic ip_trained;
    logic pws_match;
    logic pws_hit;
    logic scan_done;
    logic promote_ok;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/mtsp_req_if.sv =====
interface mtsp_req_if import mtsp_pkg::*; ();
  logic valid;
  logic ready;
  logic [PCW-1:0] pc;
  logic [WW-1:0] warp_id;
  logic [AW-1:0] access_addr;

  modport source (output valid, pc, warp_id, access_addr, input ready);
  modport sink (input valid, pc, warp_id, access_addr, output ready);
endinterface

// ===== rtl/core/mtsp_rsp_if.sv =====
interface mtsp_rsp_if import mtsp_pkg::*; ();
  logic valid;
  logic ready;
  logic prefetch_valid;
  logic [AW-1:0] prefetch_addr;
  logic [1:0] hit_source;

  modport source (output valid, prefetch_valid, prefetch_addr, hit_source, input ready);
  modport sink (input valid, prefetch_valid, prefetch_addr, hit_source, output ready);
endinterface

// ===== rtl/core/mtsp_cfg_if.sv =====
interface mtsp_cfg_if import mtsp_pkg::*; ();
  logic valid;
  logic ready;
  logic [THRW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/many_thread_stride_prefetch_engine_top.sv =====
// Stride prefetcher for many-thread workloads.
// Channel req carries one memory access request (pc, warp_id, access_addr);
// channel rsp returns exactly one result per request with prefetch_valid,
// prefetch_addr and hit_source. Both use valid/ready; a transfer happens on a
// rising clock edge with valid and ready high. Channel cfg writes the 6-bit
// promotion threshold, is always ready, and should be used only while idle.
// On a global or trained inter-warp hit a request is latched, looked up and
// loaded into the output register. Other requests go on to the per-warp
// table, after an inter-warp allocation if no inter-warp entry matches; a
// per-warp miss adds a per-warp allocation, a per-warp hit a count and
// promotion check, and a passed check a global victim search. The victim
// search walks one table entry per cycle. One request is in flight at a time.
// The result sits in an output register, so the next request is accepted while
// it waits; a stalled receiver holds the block in its final step until the
// register frees. Synchronous reset clears all valid bits, ages and observation
// counts and sets the threshold to 2; no clearing pass is needed.
module many_thread_stride_prefetch_engine_top import mtsp_pkg::*; (
  input logic clk,
  input logic rst,
  mtsp_req_if.sink req,
  mtsp_rsp_if.source rsp,
  mtsp_cfg_if.sink cfg
);

  cmd_t cmd;
  stat_t stat;

  assign cfg.ready = 1'b1;

  mtsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mtsp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_pc        (req.pc),
    .in_warp      (req.warp_id),
    .in_addr      (req.access_addr),
    .cfg_we       (cfg.valid),
    .cfg_data     (cfg.data),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_pf_valid (rsp.prefetch_valid),
    .out_pf_addr  (rsp.prefetch_addr),
    .out_src      (rsp.hit_source)
  );

endmodule

// ===== rtl/core/mtsp_datapath.sv =====
module mtsp_datapath import mtsp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cmd_t            cmd,
  output stat_t           stat,
  input  logic [PCW-1:0]  in_pc,
  input  logic [WW-1:0]   in_warp,
  input  logic [AW-1:0]   in_addr,
  input  logic            cfg_we,
  input  logic [THRW-1:0] cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_pf_valid,
  output logic [AW-1:0]   out_pf_addr,
  output logic [1:0]      out_src
);

  logic [PCW-1:0] pc_r;
  logic [WW-1:0] warp_r;
  logic [AW-1:0] addr_r;
  logic [THRW-1:0] thr;

  logic gs_valid [GS_N];
  logic [PCW-1:0] gs_pc [GS_N];
  logic [AW-1:0] gs_stride [GS_N];
  logic [AGEW-1:0] gs_age [GS_N];

  logic ip_valid [IP_N];
  logic [PCW-1:0] ip_pc [IP_N];
  logic ip_trained [IP_N];
  logic [1:0] ip_cnt [IP_N];
  logic [WW-1:0] ip_w0 [IP_N];
  logic [WW-1:0] ip_w1 [IP_N];
  logic [AW-1:0] ip_a0 [IP_N];
  logic [AW-1:0] ip_a1 [IP_N];
  logic [AW-1:0] ip_stride [IP_N];
  logic [AGEW-1:0] ip_age [IP_N];

  logic pws_valid [PWS_N];
  logic [PCW-1:0] pws_pc [PWS_N];
  logic [WW-1:0] pws_warp [PWS_N];
  logic pws_trained [PWS_N];
  logic [AW-1:0] pws_last [PWS_N];
  logic [AW-1:0] pws_stride [PWS_N];
  logic [AGEW-1:0] pws_age [PWS_N];

  logic res_valid;
  logic [AW-1:0] res_addr;
  logic [1:0] res_src;
  logic [AW-1:0] promo_stride;
  logic [PWS_N-1:0] cnt_vec;

  tbl_t scan_tbl;
  logic [SCAN_IW-1:0] scan_idx;
  logic [SCAN_IW-1:0] scan_slot;
  logic [AGEW-1:0] scan_best;
  logic scan_busy;
  logic scan_fin;

  // Tag match and first-match encoding for each table.
  logic gs_any, ip_any, pws_any;
  logic [GS_IW-1:0] gs_idx;
  logic [IP_IW-1:0] ip_idx;
  logic [PWS_IW-1:0] pws_idx;
  logic [AW-1:0] pws_delta;
  logic pws_hit_c;
  logic [AW-1:0] ip_s01, ip_s1n;
  logic ip_train_c;
  logic [PWS_N-1:0] cnt_match;
  logic [PCNT_W-1:0] cnt_total;
  logic scan_v;
  logic [AGEW-1:0] scan_a;
  logic scan_last;

  always_comb begin
    gs_any = 1'b0;
    gs_idx = '0;
    for (int i = GS_N - 1; i >= 0; i--) begin
      if (gs_valid[i] && gs_pc[i] == pc_r) begin
        gs_any = 1'b1;
        gs_idx = GS_IW'(i);
      end
    end
    ip_any = 1'b0;
    ip_idx = '0;
    for (int i = IP_N - 1; i >= 0; i--) begin
      if (ip_valid[i] && ip_pc[i] == pc_r) begin
        ip_any = 1'b1;
        ip_idx = IP_IW'(i);
      end
    end
    pws_any = 1'b0;
    pws_idx = '0;
    for (int i = PWS_N - 1; i >= 0; i--) begin
      if (pws_valid[i] && pws_pc[i] == pc_r && pws_warp[i] == warp_r) begin
        pws_any = 1'b1;
        pws_idx = PWS_IW'(i);
      end
    end
  end

  assign pws_delta = addr_r - pws_last[pws_idx];
  assign pws_hit_c = pws_any && (pws_delta == pws_stride[pws_idx]) && (pws_delta != '0);

  assign ip_s01 = ip_a1[ip_idx] - ip_a0[ip_idx];
  assign ip_s1n = addr_r - ip_a1[ip_idx];
  assign ip_train_c = (ip_s01 == ip_s1n) && (warp_r != ip_w0[ip_idx]) &&
                      (warp_r != ip_w1[ip_idx]) && (ip_w0[ip_idx] != ip_w1[ip_idx]);

  always_comb begin
    for (int i = 0; i < PWS_N; i++) begin
      cnt_match[i] = pws_valid[i] && pws_pc[i] == pc_r && pws_trained[i] &&
                     pws_stride[i] == promo_stride;
    end
    cnt_total = '0;
    for (int i = 0; i < PWS_N; i++) begin
      cnt_total = cnt_total + PCNT_W'(cnt_vec[i]);
    end
  end

  always_comb begin
    case (scan_tbl)
      TBL_GS: begin
        scan_v = gs_valid[scan_idx[GS_IW-1:0]];
        scan_a = gs_age[scan_idx[GS_IW-1:0]];
        scan_last = (scan_idx == SCAN_IW'(GS_N - 1));
      end
      TBL_IP: begin
        scan_v = ip_valid[scan_idx[IP_IW-1:0]];
        scan_a = ip_age[scan_idx[IP_IW-1:0]];
        scan_last = (scan_idx == SCAN_IW'(IP_N - 1));
      end
      default: begin
        scan_v = pws_valid[scan_idx[PWS_IW-1:0]];
        scan_a = pws_age[scan_idx[PWS_IW-1:0]];
        scan_last = (scan_idx == SCAN_IW'(PWS_N - 1));
      end
    endcase
  end

  always_comb begin
    stat.gs_hit = gs_any;
    stat.ip_match = ip_any;
    stat.ip_trained = ip_trained[ip_idx];
    stat.pws_match = pws_any;
    stat.pws_hit = pws_hit_c;
    stat.scan_done = scan_fin && !scan_busy;
    stat.promote_ok = ({{(32-PCNT_W){1'b0}}, cnt_total} >= {{(32-THRW){1'b0}}, thr});
    stat.out_free = !out_valid || out_ready;
  end

  // Victim search: first free entry, else the oldest with ties to the higher index.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_busy <= 1'b0;
      scan_fin <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_tbl <= cmd.scan_tbl;
      scan_idx <= '0;
      scan_best <= '0;
      scan_slot <= '0;
      scan_busy <= 1'b1;
      scan_fin <= 1'b0;
    end else if (scan_busy) begin
      if (!scan_v) begin
        scan_slot <= scan_idx;
        scan_busy <= 1'b0;
        scan_fin <= 1'b1;
      end else begin
        if (scan_a >= scan_best) begin
          scan_best <= scan_a;
          scan_slot <= scan_idx;
        end
        if (scan_last) begin
          scan_busy <= 1'b0;
          scan_fin <= 1'b1;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pc_r <= in_pc;
      warp_r <= in_warp;
      addr_r <= in_addr;
      res_valid <= 1'b0;
      res_addr <= '0;
      res_src <= SRC_NONE;
    end else if (cmd.res_gs) begin
      res_valid <= 1'b1;
      res_addr <= addr_r + gs_stride[gs_idx];
      res_src <= SRC_GS;
    end else if (cmd.res_ip) begin
      res_valid <= 1'b1;
      res_addr <= addr_r + ip_stride[ip_idx];
      res_src <= SRC_IP;
    end else if (cmd.pws_update && pws_hit_c) begin
      res_valid <= 1'b1;
      res_addr <= addr_r + pws_delta;
      res_src <= SRC_PWS;
    end
    if (cmd.pws_update) begin
      promo_stride <= pws_delta;
    end
    if (cmd.cnt_capture) begin
      cnt_vec <= cnt_match;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < GS_N; j++) begin
        gs_valid[j] <= 1'b0;
        gs_age[j] <= '0;
      end
    end else begin
      if (cmd.gs_touch) begin
        for (int j = 0; j < GS_N; j++) begin
          if (gs_valid[j] && gs_age[j] != AGE_MAX) begin
            gs_age[j] <= gs_age[j] + 1'b1;
          end
        end
        gs_age[gs_idx] <= '0;
      end
      if (cmd.gs_promo) begin
        gs_valid[scan_slot[GS_IW-1:0]] <= 1'b1;
        gs_pc[scan_slot[GS_IW-1:0]] <= pc_r;
        gs_stride[scan_slot[GS_IW-1:0]] <= promo_stride;
        gs_age[scan_slot[GS_IW-1:0]] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < IP_N; j++) begin
        ip_valid[j] <= 1'b0;
        ip_age[j] <= '0;
        ip_cnt[j] <= '0;
      end
    end else begin
      if (cmd.ip_touch) begin
        for (int j = 0; j < IP_N; j++) begin
          if (ip_valid[j] && ip_age[j] != AGE_MAX) begin
            ip_age[j] <= ip_age[j] + 1'b1;
          end
        end
        ip_age[ip_idx] <= '0;
      end
      if (cmd.ip_obs) begin
        if (ip_cnt[ip_idx] < OBS_SLOTS) begin
          if (ip_cnt[ip_idx] == 2'd0) begin
            ip_w0[ip_idx] <= warp_r;
            ip_a0[ip_idx] <= addr_r;
          end else begin
            ip_w1[ip_idx] <= warp_r;
            ip_a1[ip_idx] <= addr_r;
          end
          ip_cnt[ip_idx] <= ip_cnt[ip_idx] + 1'b1;
        end else if (ip_train_c) begin
          ip_stride[ip_idx] <= ip_s1n;
          ip_trained[ip_idx] <= 1'b1;
        end else begin
          ip_w0[ip_idx] <= ip_w1[ip_idx];
          ip_a0[ip_idx] <= ip_a1[ip_idx];
          ip_w1[ip_idx] <= warp_r;
          ip_a1[ip_idx] <= addr_r;
        end
      end
      if (cmd.ip_alloc) begin
        ip_valid[scan_slot[IP_IW-1:0]] <= 1'b1;
        ip_pc[scan_slot[IP_IW-1:0]] <= pc_r;
        ip_trained[scan_slot[IP_IW-1:0]] <= 1'b0;
        ip_cnt[scan_slot[IP_IW-1:0]] <= 2'd1;
        ip_w0[scan_slot[IP_IW-1:0]] <= warp_r;
        ip_a0[scan_slot[IP_IW-1:0]] <= addr_r;
        ip_stride[scan_slot[IP_IW-1:0]] <= '0;
        ip_age[scan_slot[IP_IW-1:0]] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < PWS_N; j++) begin
        pws_valid[j] <= 1'b0;
        pws_age[j] <= '0;
      end
    end else begin
      if (cmd.pws_update) begin
        for (int j = 0; j < PWS_N; j++) begin
          if (pws_valid[j] && pws_age[j] != AGE_MAX) begin
            pws_age[j] <= pws_age[j] + 1'b1;
          end
        end
        pws_age[pws_idx] <= '0;
        pws_last[pws_idx] <= addr_r;
        if (pws_hit_c) begin
          pws_trained[pws_idx] <= 1'b1;
        end else begin
          pws_stride[pws_idx] <= pws_delta;
          pws_trained[pws_idx] <= 1'b0;
        end
      end
      if (cmd.pws_alloc) begin
        pws_valid[scan_slot[PWS_IW-1:0]] <= 1'b1;
        pws_pc[scan_slot[PWS_IW-1:0]] <= pc_r;
        pws_warp[scan_slot[PWS_IW-1:0]] <= warp_r;
        pws_trained[scan_slot[PWS_IW-1:0]] <= 1'b0;
        pws_last[scan_slot[PWS_IW-1:0]] <= addr_r;
        pws_stride[scan_slot[PWS_IW-1:0]] <= '0;
        pws_age[scan_slot[PWS_IW-1:0]] <= '0;
      end
      // Promoted entries leave the per-warp table.
      if (cmd.gs_promo) begin
        for (int j = 0; j < PWS_N; j++) begin
          if (cnt_vec[j]) begin
            pws_valid[j] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pf_valid <= res_valid;
      out_pf_addr <= res_addr;
      out_src <= res_src;
    end
  end

endmodule

// ===== rtl/core/mtsp_ctrl.sv =====
module mtsp_ctrl import mtsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_IPSCAN, S_PWS, S_PWSSCAN, S_COUNT, S_CHECK, S_GSSCAN, S_FINISH
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.scan_tbl = TBL_GS;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat.gs_hit) begin
          cmd.res_gs = 1'b1;
          cmd.gs_touch = 1'b1;
          state_next = S_FINISH;
        end else if (stat.ip_match && stat.ip_trained) begin
          cmd.res_ip = 1'b1;
          cmd.ip_touch = 1'b1;
          state_next = S_FINISH;
        end else if (stat.ip_match) begin
          cmd.ip_obs = 1'b1;
          state_next = S_PWS;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_tbl = TBL_IP;
          state_next = S_IPSCAN;
        end
      end
      S_IPSCAN: begin
        if (stat.scan_done) begin
          cmd.ip_alloc = 1'b1;
          state_next = S_PWS;
        end
      end
      S_PWS: begin
        if (stat.pws_match) begin
          cmd.pws_update = 1'b1;
          state_next = stat.pws_hit ? S_COUNT : S_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_tbl = TBL_PWS;
          state_next = S_PWSSCAN;
        end
      end
      S_PWSSCAN: begin
        if (stat.scan_done) begin
          cmd.pws_alloc = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_COUNT: begin
        cmd.cnt_capture = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.promote_ok) begin
          cmd.scan_start = 1'b1;
          cmd.scan_tbl = TBL_GS;
          state_next = S_GSSCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_GSSCAN: begin
        if (stat.scan_done) begin
          cmd.gs_promo = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
typedef struct {
  logic        pv;
  logic [31:0] pa;
  logic [1:0]  src;
} prefetch_rsp_t;

class prefetch_scoreboard;
  logic [5:0]  threshold;
  bit          gs_v[], ip_v[], ip_tr[], pw_v[], pw_tr[];
  logic [31:0] gs_pc[], gs_st[], ip_pc[], ip_st[], ip_a0[], ip_a1[];
  logic [31:0] pw_pc[], pw_last[], pw_st[];
  logic [4:0]  ip_w0[], ip_w1[], pw_w[];
  logic [15:0] gs_age[], ip_age[], pw_age[];
  int          ip_cnt[];
  prefetch_rsp_t pending[$];
  int          errors;
  int          hits[4];

  function new();
    threshold = mtsp_pkg::THR_RESET;
    gs_v = new[8]; gs_pc = new[8]; gs_st = new[8]; gs_age = new[8];
    ip_v = new[8]; ip_tr = new[8]; ip_pc = new[8]; ip_st = new[8]; ip_age = new[8];
    ip_a0 = new[8]; ip_a1 = new[8]; ip_w0 = new[8]; ip_w1 = new[8]; ip_cnt = new[8];
    pw_v = new[32]; pw_tr = new[32]; pw_pc = new[32]; pw_last = new[32];
    pw_st = new[32]; pw_w = new[32]; pw_age = new[32];
    foreach (gs_age[i]) gs_age[i] = '0;
    foreach (ip_age[i]) begin
      ip_age[i] = '0;
      ip_cnt[i] = 0;
    end
    foreach (pw_age[i]) pw_age[i] = '0;
  endfunction

  function void age_table(ref bit v[], ref logic [15:0] a[], input int hit);
    foreach (v[j]) if (v[j] && a[j] != mtsp_pkg::AGE_MAX) a[j]++;
    a[hit] = '0;
  endfunction

  function int pick_slot(ref bit v[], ref logic [15:0] a[]);
    int s;
    logic [15:0] oldest;
    s = 0;
    oldest = '0;
    foreach (v[i]) begin
      if (!v[i]) return i;
      if (a[i] >= oldest) begin
        oldest = a[i];
        s = i;
      end
    end
    return s;
  endfunction

  // Promote a shared per-warp stride into the global table.
  function void try_promote(logic [31:0] pc, logic [31:0] st);
    int n, s;
    n = 0;
    foreach (pw_v[i]) if (pw_v[i] && pw_pc[i] == pc && pw_tr[i] && pw_st[i] == st) n++;
    if (n < threshold) return;
    s = pick_slot(gs_v, gs_age);
    gs_v[s] = 1; gs_pc[s] = pc; gs_st[s] = st; gs_age[s] = '0;
    foreach (pw_v[i]) if (pw_v[i] && pw_pc[i] == pc && pw_tr[i] && pw_st[i] == st) pw_v[i] = 0;
  endfunction

  function prefetch_rsp_t predict(logic [31:0] pc, logic [4:0] w, logic [31:0] a);
    prefetch_rsp_t r;
    int s;
    bit matched;
    logic [31:0] d;
    r.pv = 0; r.pa = '0; r.src = mtsp_pkg::SRC_NONE;
    foreach (gs_v[i]) if (gs_v[i] && gs_pc[i] == pc) begin
      r.pv = 1; r.pa = a + gs_st[i]; r.src = mtsp_pkg::SRC_GS;
      age_table(gs_v, gs_age, i);
      return r;
    end
    matched = 0;
    foreach (ip_v[i]) if (!matched && ip_v[i] && ip_pc[i] == pc) begin
      matched = 1;
      if (ip_tr[i]) begin
        r.pv = 1; r.pa = a + ip_st[i]; r.src = mtsp_pkg::SRC_IP;
        age_table(ip_v, ip_age, i);
        return r;
      end
      if (ip_cnt[i] == 0) begin
        ip_w0[i] = w; ip_a0[i] = a; ip_cnt[i] = 1;
      end else if (ip_cnt[i] == 1) begin
        ip_w1[i] = w; ip_a1[i] = a; ip_cnt[i] = 2;
      end else if (ip_a1[i] - ip_a0[i] == a - ip_a1[i] && w != ip_w0[i] && w != ip_w1[i]
                   && ip_w0[i] != ip_w1[i]) begin
        ip_st[i] = a - ip_a1[i]; ip_tr[i] = 1;
      end else begin
        ip_a0[i] = ip_a1[i]; ip_w0[i] = ip_w1[i]; ip_a1[i] = a; ip_w1[i] = w;
      end
    end
    if (!matched) begin
      s = pick_slot(ip_v, ip_age);
      ip_v[s] = 1; ip_pc[s] = pc; ip_tr[s] = 0; ip_cnt[s] = 1;
      ip_w0[s] = w; ip_a0[s] = a; ip_st[s] = '0; ip_age[s] = '0;
    end
    foreach (pw_v[i]) if (pw_v[i] && pw_pc[i] == pc && pw_w[i] == w) begin
      d = a - pw_last[i];
      if (d == pw_st[i] && d != 0) begin
        pw_tr[i] = 1;
        r.pv = 1; r.pa = a + d; r.src = mtsp_pkg::SRC_PWS;
      end else begin
        pw_st[i] = d; pw_tr[i] = 0;
      end
      pw_last[i] = a;
      age_table(pw_v, pw_age, i);
      if (r.pv) try_promote(pc, pw_st[i]);
      return r;
    end
    s = pick_slot(pw_v, pw_age);
    pw_v[s] = 1; pw_pc[s] = pc; pw_w[s] = w; pw_tr[s] = 0;
    pw_last[s] = a; pw_st[s] = '0; pw_age[s] = '0;
    return r;
  endfunction

  function void note_request(logic [31:0] pc, logic [4:0] w, logic [31:0] a);
    pending.push_back(predict(pc, w, a));
  endfunction

  function void check_result(logic pv, logic [31:0] pa, logic [1:0] src);
    prefetch_rsp_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: valid=%0b addr=%h src=%0d", pv, pa, src);
      return;
    end
    e = pending.pop_front();
    hits[e.src]++;
    if (pv !== e.pv || pa !== e.pa || src !== e.src) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected valid=%0b addr=%h src=%0d, got valid=%0b addr=%h src=%0d",
                 e.pv, e.pa, e.src, pv, pa, src);
    end
  endfunction
endclass

module tb_top;
  import mtsp_pkg::*;

  logic clk;
  logic rst;
  mtsp_req_if req();
  mtsp_rsp_if rsp();
  mtsp_cfg_if cfg();

  many_thread_stride_prefetch_engine_top u_top (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  prefetch_scoreboard sb = new();
  bit quiet_phase = 0;
  int n_sent = 0;

  logic [31:0] pcs[12], bases[12], strides[12];
  int          ip_k[12];
  logic [4:0]  ip_warp[12];
  int          pw_k[12][4];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("** many_thread_stride_prefetch_engine_top: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_result(rsp.prefetch_valid, rsp.prefetch_addr,
                                                          rsp.hit_source);
  end

  // Receiver alternates between stall bursts and ready stretches.
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet_phase && $urandom_range(0, 2) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic send_request(logic [31:0] pc, logic [4:0] w, logic [31:0] a);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.pc <= pc;
    req.warp_id <= w;
    req.access_addr <= a;
    do @(posedge clk); while (!req.ready);
    sb.note_request(pc, w, a);
    n_sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_threshold(logic [5:0] v);
    drain();
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.threshold = v;
  endtask

  // Mostly well-formed stride streams: even pcs walk across warps so the
  // inter-warp table trains, odd pcs walk per warp so per-warp entries train.
  task automatic random_request();
    int r, p, w;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    p = $urandom_range(0, 11);
    if (r < 10) begin
      send_request($urandom, 5'($urandom_range(0, 31)), $urandom);
    end else if (p % 2 == 0) begin
      ip_warp[p] = ip_warp[p] + 5'($urandom_range(1, 3));
      a = bases[p] + strides[p] * ip_k[p];
      ip_k[p]++;
      send_request(pcs[p], ip_warp[p], a);
    end else begin
      w = $urandom_range(0, 3);
      a = bases[p] + w * 32'h0001_0000 + strides[p] * pw_k[p][w];
      pw_k[p][w]++;
      if (r < 14) a = $urandom;
      send_request(pcs[p], 5'(w), a);
    end
  endtask

  initial begin
    logic [5:0] thr_list[6];
    thr_list = '{6'd1, 6'd3, 6'd32, 6'd0, 6'd63, 6'd2};
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.pc <= '0;
    req.warp_id <= '0;
    req.access_addr <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    foreach (pcs[i]) begin
      pcs[i] = $urandom;
      bases[i] = $urandom;
      ip_k[i] = 0;
      ip_warp[i] = 5'($urandom_range(0, 31));
      for (int j = 0; j < 4; j++) pw_k[i][j] = 0;
      case (i % 4)
        0: strides[i] = 32'd64;
        1: strides[i] = 32'hFFFF_FFFC;
        2: strides[i] = $urandom;
        default: strides[i] = 32'd4 << $urandom_range(0, 6);
      endcase
    end
    pcs[0] = 32'h0000_0000;
    pcs[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Per-warp training that wraps the address space, then a promotion.
    send_request(32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFF0);
    send_request(32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFF8);
    send_request(32'hFFFF_FFFF, 5'd31, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 5'd0, 32'h0000_1000);
    send_request(32'hFFFF_FFFF, 5'd0, 32'h0000_1008);
    send_request(32'hFFFF_FFFF, 5'd0, 32'h0000_1010);
    send_request(32'hFFFF_FFFF, 5'd7, 32'h0000_0000);
    // A stride of zero never trains.
    send_request(32'h0000_0000, 5'd0, 32'h0000_0000);
    send_request(32'h0000_0000, 5'd0, 32'h0000_0000);
    send_request(32'h0000_0000, 5'd0, 32'h0000_0000);
    // Three distinct warps with an equal stride train the inter-warp table.
    send_request(32'h1234_5678, 5'd1, 32'hFFFF_FF00);
    send_request(32'h1234_5678, 5'd2, 32'hFFFF_FF80);
    send_request(32'h1234_5678, 5'd3, 32'h0000_0000);
    send_request(32'h1234_5678, 5'd9, 32'h0000_4000);
    // Repeated warp makes the inter-warp window slide before the entry trains.
    send_request(32'h0BAD_0000, 5'd4, 32'h100);
    send_request(32'h0BAD_0000, 5'd4, 32'h200);
    send_request(32'h0BAD_0000, 5'd5, 32'h300);
    send_request(32'h0BAD_0000, 5'd6, 32'h400);
    // Fill the inter-warp table past capacity so victims are chosen by age.
    for (int i = 0; i < 8; i++) send_request(32'hA000_0000 + i, 5'(i), 32'h10 * i);

    foreach (thr_list[t]) begin
      write_threshold(thr_list[t]);
      for (int i = 0; i < 180; i++) random_request();
    end
    quiet_phase = 1;
    for (int i = 0; i < 100; i++) random_request();
    drain();

    $display("%0d requests sent; results by source: none %0d, global %0d, inter-warp %0d, per-warp %0d",
             n_sent, sb.hits[0], sb.hits[1], sb.hits[2], sb.hits[3]);
    $display("threshold settings 2, 1, 3, 32, 0, 63 and 2 exercised; %0d mismatches", sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** many_thread_stride_prefetch_engine_top: PASSED **");
    end else begin
      $display("** many_thread_stride_prefetch_engine_top: FAILED **");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/mtsp_pkg.sv
rtl/core/mtsp_req_if.sv
rtl/core/mtsp_rsp_if.sv
rtl/core/mtsp_cfg_if.sv
rtl/core/mtsp_datapath.sv
rtl/core/mtsp_ctrl.sv
rtl/core/many_thread_stride_prefetch_engine_top.sv
dv/tb_top.sv
